/* src/conv2d_stride_pad_engine_top_macros.svh */
// Assertion macros shared by the convolution engine RTL.
`ifndef CONV2D_STRIDE_PAD_ENGINE_TOP_MACROS_SVH
`define CONV2D_STRIDE_PAD_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define CONV2D_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define CONV2D_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/conv2d_pkg.sv */
// Package with the sizes, codes and types of the convolution engine.
package conv2d_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int MAX_DIM      = 64;
    localparam int MAX_KERNEL   = 7;
    localparam int MAX_STRIDE   = 4;
    localparam int DATA_WIDTH   = 16;

    localparam int IN_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int W_DEPTH  = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;

    localparam int IN_AW  = $clog2(IN_DEPTH);
    localparam int W_AW   = $clog2(W_DEPTH);
    localparam int IDX_W  = 16;
    localparam int RES_W  = 32;
    localparam int ACC_W  = 42;
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [RES_W-1:0]      t_result;

    // Operation codes of the func field.
    localparam logic [1:0] FUNC_LOAD_INPUT  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] FUNC_LOAD_BIAS   = 2'd2;
    localparam logic [1:0] FUNC_COMPUTE     = 2'd3;

    // Register indexes, at byte address 4 * index.
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
    localparam logic [2:0] REG_IN_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_IN_WIDTH     = 3'd3;
    localparam logic [2:0] REG_KERNEL_SIZE  = 3'd4;
    localparam logic [2:0] REG_STRIDE_STEP  = 3'd5;
    localparam logic [2:0] REG_PAD_AMOUNT   = 3'd6;

endpackage

/* src/conv2d_stride_pad_engine_top.sv */
// Top level of the strided, zero-padded 2-D convolution engine.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       func, store_index, load_value,
//                                                      req_channel, req_row, req_col
//   result    out        o_out_valid / i_out_ready     conv_result, res_channel, res_row,
//                                                      res_col, coord_error
//   config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A load transaction writes one entry of the input, weight or bias store. A compute
// transaction for an in-range position goes through two setup states, a run state that
// walks every kernel tap of every input channel in turn, issuing a multiply-accumulate
// for each tap inside the map through the single read port of each large store, a drain
// state and a finish state that hands the result over; a flagged one skips to finish.
// Reset restores the register defaults; the stores are not cleared and hold garbage
// until written. A finished result waits in the output register, so loads are taken
// meanwhile; a later compute holds in its finish state until that register frees up.

`include "conv2d_stride_pad_engine_top_macros.svh"

module conv2d_stride_pad_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [conv2d_pkg::IDX_W-1:0]    i_store_index,
    input  conv2d_pkg::t_data               i_load_value,
    input  logic [3:0]                      i_req_channel,
    input  logic [5:0]                      i_req_row,
    input  logic [5:0]                      i_req_col,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output conv2d_pkg::t_result             o_conv_result,
    output logic [3:0]                      o_res_channel,
    output logic [5:0]                      o_res_row,
    output logic [5:0]                      o_res_col,
    output logic                            o_coord_error,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [conv2d_pkg::CFG_AW-1:0]   paddr,
    input  logic [conv2d_pkg::CFG_DW-1:0]   pwdata,
    output logic [conv2d_pkg::CFG_DW-1:0]   prdata,
    output logic                            pready
);

    import conv2d_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_SETUP2 = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers, kept as written so that a read returns them.
    // ------------------------------------------------------------------
    logic [4:0] r_cfg_ic;
    logic [4:0] r_cfg_oc;
    logic [6:0] r_cfg_h;
    logic [6:0] r_cfg_w;
    logic [2:0] r_cfg_k;
    logic [2:0] r_cfg_s;
    logic [1:0] r_cfg_p;

    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ic <= 5'd1;
            r_cfg_oc <= 5'd1;
            r_cfg_h  <= 7'd64;
            r_cfg_w  <= 7'd64;
            r_cfg_k  <= 3'd3;
            r_cfg_s  <= 3'd1;
            r_cfg_p  <= 2'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_IN_CHANNELS:  r_cfg_ic <= pwdata[4:0];
                REG_OUT_CHANNELS: r_cfg_oc <= pwdata[4:0];
                REG_IN_HEIGHT:    r_cfg_h  <= pwdata[6:0];
                REG_IN_WIDTH:     r_cfg_w  <= pwdata[6:0];
                REG_KERNEL_SIZE:  r_cfg_k  <= pwdata[2:0];
                REG_STRIDE_STEP:  r_cfg_s  <= pwdata[2:0];
                REG_PAD_AMOUNT:   r_cfg_p  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IN_CHANNELS:  prdata = CFG_DW'(r_cfg_ic);
            REG_OUT_CHANNELS: prdata = CFG_DW'(r_cfg_oc);
            REG_IN_HEIGHT:    prdata = CFG_DW'(r_cfg_h);
            REG_IN_WIDTH:     prdata = CFG_DW'(r_cfg_w);
            REG_KERNEL_SIZE:  prdata = CFG_DW'(r_cfg_k);
            REG_STRIDE_STEP:  prdata = CFG_DW'(r_cfg_s);
            REG_PAD_AMOUNT:   prdata = CFG_DW'(r_cfg_p);
            default:          prdata = '0;
        endcase
    end

    // Values actually used: apart from the padding, which is used as written, a zero
    // setting counts as one, and a setting past the hardware limit counts as that limit.
    logic [4:0] cfg_ic;
    logic [4:0] cfg_oc;
    logic [6:0] cfg_h;
    logic [6:0] cfg_w;
    logic [2:0] cfg_k;
    logic [2:0] cfg_s;
    logic [1:0] cfg_p;

    always_comb begin
        cfg_ic = (r_cfg_ic == '0) ? 5'd1 :
                 (r_cfg_ic > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : r_cfg_ic;
        cfg_oc = (r_cfg_oc == '0) ? 5'd1 :
                 (r_cfg_oc > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : r_cfg_oc;
        cfg_h  = (r_cfg_h == '0) ? 7'd1 :
                 (r_cfg_h > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_cfg_h;
        cfg_w  = (r_cfg_w == '0) ? 7'd1 :
                 (r_cfg_w > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_cfg_w;
        cfg_k  = (r_cfg_k == '0) ? 3'd1 :
                 (r_cfg_k > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : r_cfg_k;
        cfg_s  = (r_cfg_s == '0) ? 3'd1 :
                 (r_cfg_s > 3'(MAX_STRIDE)) ? 3'(MAX_STRIDE) : r_cfg_s;
        cfg_p  = r_cfg_p;
    end

    // ------------------------------------------------------------------
    // Input handshake and store writes.
    // ------------------------------------------------------------------
    logic [2:0] r_state;
    logic       in_acc;
    logic       wr_input;
    logic       wr_weight;
    logic       wr_bias;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign wr_input   = in_acc && (i_func == FUNC_LOAD_INPUT);
    assign wr_weight  = in_acc && (i_func == FUNC_LOAD_WEIGHT)
                        && (i_store_index < IDX_W'(W_DEPTH));
    assign wr_bias    = in_acc && (i_func == FUNC_LOAD_BIAS)
                        && (i_store_index < IDX_W'(MAX_CHANNELS));

    // The two large stores are synchronous memories with one read port each.
    t_data m_input_store  [IN_DEPTH];
    t_data m_weight_store [W_DEPTH];
    t_data r_bias_store   [MAX_CHANNELS];

    logic [IN_AW-1:0] rd_in_addr;
    logic [W_AW-1:0]  r_wa;
    t_data            r_pix;
    t_data            r_wgt;

    always_ff @(posedge i_clk) begin
        if (wr_input) begin
            m_input_store[i_store_index[IN_AW-1:0]] <= i_load_value;
        end
        r_pix <= m_input_store[rd_in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_weight) begin
            m_weight_store[i_store_index[W_AW-1:0]] <= i_load_value;
        end
        r_wgt <= m_weight_store[r_wa];
    end

    always_ff @(posedge i_clk) begin
        if (wr_bias) begin
            r_bias_store[i_store_index[3:0]] <= i_load_value;
        end
    end

    // ------------------------------------------------------------------
    // Request setup. The range test avoids a divide: a row index is inside
    // the output exactly when row * stride + kernel fits in the padded height.
    // ------------------------------------------------------------------
    logic [3:0]        r_rc;
    logic [5:0]        r_rr;
    logic [5:0]        r_rk;
    logic              r_err;

    logic [9:0]        row_need;
    logic [9:0]        col_need;
    logic [9:0]        pad_h;
    logic [9:0]        pad_w;
    logic              pos_err;
    logic signed [9:0] row_start;
    logic signed [9:0] col_start;

    assign row_need  = 10'(r_rr) * 10'(cfg_s) + 10'(cfg_k);
    assign col_need  = 10'(r_rk) * 10'(cfg_s) + 10'(cfg_k);
    assign pad_h     = 10'(cfg_h) + 10'({cfg_p, 1'b0});
    assign pad_w     = 10'(cfg_w) + 10'({cfg_p, 1'b0});
    assign pos_err   = ({1'b0, r_rc} >= cfg_oc) || (row_need > pad_h) || (col_need > pad_w);
    assign row_start = 10'(r_rr) * 10'(cfg_s) - 10'(cfg_p);
    assign col_start = 10'(r_rk) * 10'(cfg_s) - 10'(cfg_p);

    logic [12:0]        r_hw;
    logic [5:0]         r_kk;
    logic [8:0]         r_rc_icn;
    logic signed [9:0]  r_ir0;
    logic signed [9:0]  r_col0;

    // Walk registers: input row and column, row offset into the map, base of
    // the current input channel, and the three loop counters.
    logic signed [9:0]  r_ir;
    logic signed [9:0]  r_icol;
    logic signed [17:0] r_row_off;
    logic signed [17:0] r_row_off0;
    logic [16:0]        r_chan_base;
    logic [3:0]         r_ic;
    logic [2:0]         r_kr;
    logic [2:0]         r_kc;

    logic               last_kc;
    logic               last_kr;
    logic               last_ic;
    logic               in_bounds;
    logic [17:0]        ia_full;

    assign last_kc   = (r_kc == cfg_k - 3'd1);
    assign last_kr   = (r_kr == cfg_k - 3'd1);
    assign last_ic   = ({1'b0, r_ic} == cfg_ic - 5'd1);
    assign in_bounds = !r_ir[9] && (unsigned'(r_ir) < 10'(cfg_h))
                       && !r_icol[9] && (unsigned'(r_icol) < 10'(cfg_w));
    assign ia_full   = {1'b0, r_chan_base} + r_row_off + {{8{r_icol[9]}}, r_icol};
    assign rd_in_addr = ia_full[IN_AW-1:0];

    // MAC pipeline: read, multiply, accumulate.
    logic                     r_p1_vld;
    logic                     r_p2_vld;
    logic signed [RES_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_data                    bias_val;

    assign bias_val = r_bias_store[r_rc];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= (r_state == ST_RUN) && in_bounds;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_pix * r_wgt;
    end

    // ------------------------------------------------------------------
    // Result formatting and output register.
    // ------------------------------------------------------------------
    t_result sat_val;
    logic    out_load;

    always_comb begin
        if (!r_acc[ACC_W-1] && (|r_acc[ACC_W-2:RES_W-1])) begin
            sat_val = {1'b0, {(RES_W-1){1'b1}}};
        end else if (r_acc[ACC_W-1] && !(&r_acc[ACC_W-2:RES_W-1])) begin
            sat_val = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            sat_val = r_acc[RES_W-1:0];
        end
    end

    assign out_load = (r_state == ST_FINISH) && (!o_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_conv_result <= r_err ? '0 : sat_val;
            o_res_channel <= r_rc;
            o_res_row     <= r_rr;
            o_res_col     <= r_rk;
            o_coord_error <= r_err;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_func == FUNC_COMPUTE)) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= pos_err ? ST_FINISH : ST_SETUP2;
                end
                ST_SETUP2: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (last_kc && last_kr && last_ic) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_p1_vld && !r_p2_vld) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the walk; they need no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_rc <= i_req_channel;
                    r_rr <= i_req_row;
                    r_rk <= i_req_col;
                end
            end
            ST_SETUP: begin
                r_err    <= pos_err;
                r_hw     <= 13'(cfg_h) * 13'(cfg_w);
                r_kk     <= 6'(cfg_k) * 6'(cfg_k);
                r_rc_icn <= 9'(r_rc) * 9'(cfg_ic);
                r_ir0    <= row_start;
                r_col0   <= col_start;
            end
            ST_SETUP2: begin
                r_wa        <= W_AW'(r_rc_icn) * W_AW'(r_kk);
                r_row_off   <= 18'(r_ir0) * 18'($signed({1'b0, cfg_w}));
                r_row_off0  <= 18'(r_ir0) * 18'($signed({1'b0, cfg_w}));
                r_ir        <= r_ir0;
                r_icol      <= r_col0;
                r_chan_base <= '0;
                r_ic        <= '0;
                r_kr        <= '0;
                r_kc        <= '0;
                r_acc       <= {{(ACC_W-DATA_WIDTH-8){bias_val[DATA_WIDTH-1]}}, bias_val, 8'd0};
            end
            ST_RUN: begin
                r_wa <= r_wa + W_AW'(1);
                if (!last_kc) begin
                    r_kc   <= r_kc + 3'd1;
                    r_icol <= r_icol + 10'sd1;
                end else begin
                    r_kc   <= '0;
                    r_icol <= r_col0;
                    if (!last_kr) begin
                        r_kr      <= r_kr + 3'd1;
                        r_ir      <= r_ir + 10'sd1;
                        r_row_off <= r_row_off + 18'($signed({1'b0, cfg_w}));
                    end else begin
                        r_kr        <= '0;
                        r_ir        <= r_ir0;
                        r_row_off   <= r_row_off0;
                        r_ic        <= r_ic + 4'd1;
                        r_chan_base <= r_chan_base + 17'(r_hw);
                    end
                end
                if (r_p2_vld) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            ST_DRAIN: begin
                if (r_p2_vld) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CONV2D_ASSERT_IMP(a_idle_pipe_empty, r_state == ST_IDLE, !r_p1_vld && !r_p2_vld, "MAC pipeline not empty when idle")
    `CONV2D_ASSERT_IMP(a_wa_in_store, r_state == ST_RUN, r_wa < W_AW'(W_DEPTH), "weight address past the weight store")
    `CONV2D_ASSERT_IMP(a_err_zero, o_out_valid && o_coord_error, o_conv_result == '0, "flagged result is not zero")
    `CONV2D_ASSERT_NXT(a_compute_starts, in_acc && i_func == FUNC_COMPUTE, r_state == ST_SETUP, "compute transaction did not start setup")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the strided, zero-padded 2-D convolution engine.
module tb;
    import conv2d_pkg::*;

    // Cycles the receiver holds off during the output stall test.
    localparam int HOLD_CYCLES = 2000;
    // Cycles to let pass after the last result before a register write or the end.
    localparam int QUIET_CYCLES = 16;
    localparam int TAIL_CYCLES  = 100;
    // Hard stop, far beyond the slowest correct run.
    localparam int RUN_LIMIT = 8_000_000;
    // Cap on printed failure lines.
    localparam int PRINT_CAP = 40;

    // One result transaction as the block returns it.
    typedef struct packed {
        t_result    sum;
        logic [3:0] ch;
        logic [5:0] row;
        logic [5:0] col;
        logic       flag;
    } conv_out_t;

    // Register settings as the block uses them, after clamping.
    typedef struct {
        int ic;
        int oc;
        int h;
        int w;
        int k;
        int s;
        int p;
        int oh;
        int ow;
    } geom_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = FUNC_LOAD_INPUT;
    logic [15:0] i_store_index = '0;
    t_data       i_load_value = '0;
    logic [3:0]  i_req_channel = '0;
    logic [5:0]  i_req_row = '0;
    logic [5:0]  i_req_col = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_result     o_conv_result;
    logic [3:0]  o_res_channel;
    logic [5:0]  o_res_row;
    logic [5:0]  o_res_col;
    logic        o_coord_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic        pready;

    conv2d_stride_pad_engine_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_store_index (i_store_index),
        .i_load_value  (i_load_value),
        .i_req_channel (i_req_channel),
        .i_req_row     (i_req_row),
        .i_req_col     (i_req_col),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_conv_result (o_conv_result),
        .o_res_channel (o_res_channel),
        .o_res_row     (o_res_row),
        .o_res_col     (o_res_col),
        .o_coord_error (o_coord_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Mirror of the block's stores. The set flags record which entries have been
    // written, so that a compute never reads an entry that still holds garbage.
    t_data pixel_mem  [IN_DEPTH];
    t_data weight_mem [W_DEPTH];
    t_data bias_mem   [MAX_CHANNELS];
    bit    pixel_set  [IN_DEPTH];
    bit    weight_set [W_DEPTH];
    bit    bias_set   [MAX_CHANNELS];

    // Mirror of the registers as written, masked to their widths.
    logic [4:0] cfg_in_ch  = 5'd1;
    logic [4:0] cfg_out_ch = 5'd1;
    logic [6:0] cfg_height = 7'd64;
    logic [6:0] cfg_width  = 7'd64;
    logic [2:0] cfg_kernel = 3'd3;
    logic [2:0] cfg_stride = 3'd1;
    logic [1:0] cfg_pad    = 2'd0;

    // Convolution outputs still owed by the block, oldest first.
    conv_out_t pending_results[$];

    int err_count    = 0;
    // When set, neither side inserts idle cycles.
    bit steady_flow  = 1'b0;
    // Set by the stall test; the receiver clears it when its hold-off is over.
    bit hold_results = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Out-of-range register values fall back to the nearest bound.
    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Output positions along one axis; zero when the kernel exceeds the padded input.
    function automatic int out_dim(int n, int p, int k, int s);
        int padded;
        padded = n + 2 * p;
        if (padded < k) return 0;
        return (padded - k) / s + 1;
    endfunction

    function automatic geom_t active_geom();
        geom_t g;
        g.ic = clamp_dim(cfg_in_ch, MAX_CHANNELS);
        g.oc = clamp_dim(cfg_out_ch, MAX_CHANNELS);
        g.h  = clamp_dim(cfg_height, MAX_DIM);
        g.w  = clamp_dim(cfg_width, MAX_DIM);
        g.k  = clamp_dim(cfg_kernel, MAX_KERNEL);
        g.s  = clamp_dim(cfg_stride, MAX_STRIDE);
        g.p  = cfg_pad;
        g.oh = out_dim(g.h, g.p, g.k, g.s);
        g.ow = out_dim(g.w, g.p, g.k, g.s);
        return g;
    endfunction

    // Expected output for one compute request: bias in Q16.16 plus the exact sum of
    // the Q8.8 products over the window, saturated once to 32 bits. Padding taps are
    // skipped, which is the same as multiplying by a zero pixel.
    function automatic conv_out_t predict_conv_output(logic [3:0] ch, logic [5:0] row,
                                                      logic [5:0] col);
        geom_t g;
        conv_out_t r;
        logic signed [63:0] acc;
        int ir, icl, ia, wa;
        g = active_geom();
        r.ch   = ch;
        r.row  = row;
        r.col  = col;
        r.flag = (ch >= g.oc) || (row >= g.oh) || (col >= g.ow);
        r.sum  = '0;
        if (!r.flag) begin
            acc = bias_mem[ch];
            acc = acc * 256;
            for (int ic = 0; ic < g.ic; ic++) begin
                for (int kr = 0; kr < g.k; kr++) begin
                    for (int kc = 0; kc < g.k; kc++) begin
                        ir  = int'(row) * g.s + kr - g.p;
                        icl = int'(col) * g.s + kc - g.p;
                        if (ir < 0 || icl < 0 || ir >= g.h || icl >= g.w) continue;
                        ia  = ic * g.h * g.w + ir * g.w + icl;
                        wa  = ((int'(ch) * g.ic + ic) * g.k + kr) * g.k + kc;
                        acc = acc + pixel_mem[ia] * weight_mem[wa];
                    end
                end
            end
            if (acc > 64'sd2147483647) r.sum = 32'h7FFF_FFFF;
            else if (acc < -64'sd2147483648) r.sum = 32'h8000_0000;
            else r.sum = acc[31:0];
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Q8.8 values: small ones keep sums in range, extremes drive saturation.
    function automatic t_data pick_value();
        int r;
        t_data v;
        r = $urandom_range(0, 9);
        if (r < 4) v = t_data'($urandom_range(0, 511) - 256);
        else if (r < 8) v = t_data'($urandom);
        else begin
            case ($urandom_range(0, 3))
                0: v = 16'sh8000;
                1: v = 16'sh7FFF;
                2: v = -16'sd1;
                default: v = 16'sd0;
            endcase
        end
        return v;
    endfunction

    function automatic int reg_width(logic [2:0] idx);
        case (idx)
            REG_IN_CHANNELS, REG_OUT_CHANNELS: return 5;
            REG_IN_HEIGHT, REG_IN_WIDTH:       return 7;
            REG_KERNEL_SIZE, REG_STRIDE_STEP:  return 3;
            default:                           return 2;
        endcase
    endfunction

    // Offer one input transaction and hold it until accepted. The mirror is updated
    // at the accepting edge, so the expectation sees every earlier load.
    task automatic send_item(logic [1:0] f, logic [15:0] idx, t_data val,
                             logic [3:0] ch, logic [5:0] row, logic [5:0] col);
        int gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_store_index <= idx;
        i_load_value  <= val;
        i_req_channel <= ch;
        i_req_row     <= row;
        i_req_col     <= col;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        case (f)
            FUNC_LOAD_INPUT: begin
                pixel_mem[idx] = val;
                pixel_set[idx] = 1'b1;
            end
            FUNC_LOAD_WEIGHT: begin
                if (idx < W_DEPTH) begin
                    weight_mem[idx] = val;
                    weight_set[idx] = 1'b1;
                end
            end
            FUNC_LOAD_BIAS: begin
                if (idx < MAX_CHANNELS) begin
                    bias_mem[idx[3:0]] = val;
                    bias_set[idx[3:0]] = 1'b1;
                end
            end
            FUNC_COMPUTE: pending_results.push_back(predict_conv_output(ch, row, col));
        endcase
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Load with random content in the unused request fields.
    task automatic send_load(logic [1:0] f, logic [15:0] idx, t_data val);
        send_item(f, idx, val, 4'($urandom), 6'($urandom), 6'($urandom));
    endtask

    // Write every store entry that the window of this output reads and that has
    // never been written, so the compute sees only defined data.
    task automatic fill_window(logic [3:0] ch, logic [5:0] row, logic [5:0] col);
        geom_t g;
        int ir, icl, ia, wa;
        g = active_geom();
        if (ch >= g.oc || row >= g.oh || col >= g.ow) return;
        if (!bias_set[ch]) send_load(FUNC_LOAD_BIAS, 16'(ch), pick_value());
        for (int ic = 0; ic < g.ic; ic++) begin
            for (int kr = 0; kr < g.k; kr++) begin
                for (int kc = 0; kc < g.k; kc++) begin
                    ir  = int'(row) * g.s + kr - g.p;
                    icl = int'(col) * g.s + kc - g.p;
                    if (ir < 0 || icl < 0 || ir >= g.h || icl >= g.w) continue;
                    ia = ic * g.h * g.w + ir * g.w + icl;
                    wa = ((int'(ch) * g.ic + ic) * g.k + kr) * g.k + kc;
                    if (!pixel_set[ia]) send_load(FUNC_LOAD_INPUT, 16'(ia), pick_value());
                    if (!weight_set[wa]) send_load(FUNC_LOAD_WEIGHT, 16'(wa), pick_value());
                end
            end
        end
    endtask

    task automatic send_compute(logic [3:0] ch, logic [5:0] row, logic [5:0] col);
        fill_window(ch, row, col);
        send_item(FUNC_COMPUTE, 16'($urandom), t_data'($urandom), ch, row, col);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Two-phase register write. Bits above the register's width carry noise, which
    // the block is expected to drop.
    task automatic write_reg(logic [2:0] idx, int value);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (32'd1 << reg_width(idx)) - 32'd1;
        data = ($urandom & ~mask) | (32'(value) & mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_IN_CHANNELS:  cfg_in_ch  = data[4:0];
            REG_OUT_CHANNELS: cfg_out_ch = data[4:0];
            REG_IN_HEIGHT:    cfg_height = data[6:0];
            REG_IN_WIDTH:     cfg_width  = data[6:0];
            REG_KERNEL_SIZE:  cfg_kernel = data[2:0];
            REG_STRIDE_STEP:  cfg_stride = data[2:0];
            REG_PAD_AMOUNT:   cfg_pad    = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(int ic, int oc, int h, int w, int k, int s, int p);
        settle();
        write_reg(REG_IN_CHANNELS, ic);
        write_reg(REG_OUT_CHANNELS, oc);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_KERNEL_SIZE, k);
        write_reg(REG_STRIDE_STEP, s);
        write_reg(REG_PAD_AMOUNT, p);
    endtask

    // Reset values: one channel, a 64 by 64 map, 3 by 3 kernel, so outputs span 0..61.
    task automatic test_reset_defaults();
        send_compute(4'd0, 6'd0, 6'd0);
        send_compute(4'd0, 6'd61, 6'd61);
        send_compute(4'd0, 6'd62, 6'd5);
        send_compute(4'd0, 6'd5, 6'd62);
        send_compute(4'd1, 6'd0, 6'd0);
    endtask

    // Registers below their range act as 1, above it as the upper bound; padding is used as written.
    task automatic test_register_bounds();
        set_geometry(0, 0, 0, 0, 0, 0, 0);
        send_compute(4'd0, 6'd0, 6'd0);
        send_compute(4'd0, 6'd0, 6'd1);
        send_compute(4'd0, 6'd1, 6'd0);
        // 16 channels, 64 by 64, kernel 7, stride 4, pad 3: a 16 by 16 output.
        set_geometry(31, 31, 127, 127, 7, 7, 3);
        send_compute(4'd15, 6'd15, 6'd15);
        send_compute(4'd15, 6'd0, 6'd0);
        send_compute(4'd15, 6'd16, 6'd0);
        send_compute(4'd0, 6'd0, 6'd16);
        set_geometry(16, 16, 64, 64, 7, 4, 3);
        send_compute(4'd15, 6'd8, 6'd3);
    endtask

    // Tiny maps where the kernel exceeds the padded input, and padding that rescues it.
    task automatic test_small_maps();
        set_geometry(1, 1, 1, 1, 3, 1, 0);
        send_compute(4'd0, 6'd0, 6'd0);
        set_geometry(1, 1, 1, 1, 3, 1, 1);
        send_compute(4'd0, 6'd0, 6'd0);
        set_geometry(1, 1, 2, 2, 7, 1, 2);
        send_compute(4'd0, 6'd0, 6'd0);
        set_geometry(1, 1, 2, 2, 7, 1, 3);
        send_compute(4'd0, 6'd1, 6'd1);
        set_geometry(2, 1, 5, 5, 3, 2, 1);
        send_compute(4'd0, 6'd2, 6'd2);
        send_compute(4'd0, 6'd3, 6'd0);
    endtask

    // Extreme data drives the sum past both 32-bit limits; writes beyond the weight
    // and bias stores must leave the stored values untouched.
    task automatic test_saturation();
        set_geometry(1, 1, 3, 3, 3, 1, 0);
        for (int i = 0; i < 9; i++) begin
            send_load(FUNC_LOAD_INPUT, 16'(i), 16'sh8000);
            send_load(FUNC_LOAD_WEIGHT, 16'(i), 16'sh8000);
        end
        send_load(FUNC_LOAD_BIAS, 16'd0, 16'sh7FFF);
        send_compute(4'd0, 6'd0, 6'd0);
        for (int i = 0; i < 9; i++) send_load(FUNC_LOAD_WEIGHT, 16'(i), 16'sh7FFF);
        send_load(FUNC_LOAD_BIAS, 16'd0, 16'sh8000);
        send_compute(4'd0, 6'd0, 6'd0);
        for (int i = 0; i < 9; i++) send_load(FUNC_LOAD_WEIGHT, 16'(i), 16'sh0001);
        send_compute(4'd0, 6'd0, 6'd0);
        send_load(FUNC_LOAD_WEIGHT, 16'(W_DEPTH), 16'sh7FFF);
        send_load(FUNC_LOAD_WEIGHT, 16'hFFFF, 16'sh7FFF);
        send_load(FUNC_LOAD_BIAS, 16'd16, 16'sh1234);
        send_load(FUNC_LOAD_BIAS, 16'hFFFF, 16'sh1234);
        send_compute(4'd0, 6'd0, 6'd0);
    endtask

    // The receiver holds off for a long stretch while computes keep coming, so the
    // output register fills and the block stops taking input.
    task automatic test_output_stall();
        set_geometry(1, 2, 8, 8, 1, 1, 0);
        hold_results = 1'b1;
        for (int i = 0; i < 24; i++)
            send_compute(4'($urandom_range(0, 1)), 6'($urandom_range(0, 7)),
                         6'($urandom_range(0, 7)));
    endtask

    // Random settings, mostly small, with random loads, in-range computes and noise.
    task automatic test_random_traffic();
        geom_t g;
        logic [1:0] f;
        int span;
        int idx;
        for (int phase = 0; phase < 8; phase++) begin
            set_geometry($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 4),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                   : $urandom_range(1, 12),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                   : $urandom_range(1, 12),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 5),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 4),
                         $urandom_range(0, 3));
            steady_flow = ($urandom_range(0, 3) == 0);
            g = active_geom();
            for (int n = 0; n < 95; n++) begin
                if ($urandom_range(0, 99) < 55) begin
                    if (g.oh > 0 && g.ow > 0 && $urandom_range(0, 6) != 0)
                        send_compute(4'($urandom_range(0, g.oc - 1)),
                                     6'($urandom_range(0, (g.oh > 64 ? 64 : g.oh) - 1)),
                                     6'($urandom_range(0, (g.ow > 64 ? 64 : g.ow) - 1)));
                    else
                        send_compute(4'($urandom), 6'($urandom), 6'($urandom));
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            f = FUNC_LOAD_INPUT;
                            span = g.ic * g.h * g.w;
                        end
                        1: begin
                            f = FUNC_LOAD_WEIGHT;
                            span = g.oc * g.ic * g.k * g.k;
                        end
                        default: begin
                            f = FUNC_LOAD_BIAS;
                            span = g.oc;
                        end
                    endcase
                    // A quarter of the loads hit any index, many of them past the store.
                    idx = ($urandom_range(0, 3) == 0) ? int'($urandom & 32'hFFFF)
                                                      : $urandom_range(0, span - 1);
                    send_load(f, 16'(idx), pick_value());
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    // Result side: ready is mostly high with random gaps, and once held low for a
    // long, counted stretch when the stall test asks for it.
    initial begin : result_sink
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_results = 1'b0;
            end else begin
                n = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                if (n == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (n - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Every result transaction is matched against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        conv_out_t got;
        conv_out_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_conv_result, o_res_channel, o_res_row, o_res_col, o_coord_error};
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= PRINT_CAP)
                    $display("%0t: unexpected result sum %0d ch %0d row %0d col %0d err %0b",
                             $time, $signed(got.sum), got.ch, got.row, got.col, got.flag);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= PRINT_CAP)
                        $display({"%0t: mismatch, expected sum %0d ch %0d row %0d col %0d ",
                                  "err %0b, actual sum %0d ch %0d row %0d col %0d err %0b"},
                                 $time, $signed(want.sum), want.ch, want.row, want.col,
                                 want.flag, $signed(got.sum), got.ch, got.row, got.col,
                                 got.flag);
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_bounds();
        test_small_maps();
        test_saturation();
        test_output_stall();
        test_random_traffic();
        settle();
        // Any stray result after the last expected one is caught by the checker.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/conv2d_pkg.sv
src/conv2d_stride_pad_engine_top.sv
tb/tb.sv
